// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Concurrent assertion on clk / arst_n.
`define ASSERT_DEFAULT(label, prop, msg) \
	`ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// File: rtl/core/psl_pkg.sv
// Types and constants for the per-source connection limiter.
`timescale 1ns / 1ps

package psl_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned COUNT_W = 16;

	localparam logic [COUNT_W-1:0] MAX_RESET = 16'd10;

	typedef enum logic {
		KIND_CONNECT = 1'b0,
		KIND_CLOSE   = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_GRANT_HIT  = 3'd0,
		ST_GRANT_NEW  = 3'd1,
		ST_DENY_LIMIT = 3'd2,
		ST_DENY_FULL  = 3'd3,
		ST_RELEASED   = 3'd4,
		ST_UNMATCHED  = 3'd5
	} status_t;

	// Request token moving down the cell chain.
	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [KEY_W-1:0]   addr;
		logic               done;
		logic               allowed;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} token_t;

endpackage

// File: rtl/core/psl_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps

interface psl_req_if;
	logic                      valid;
	logic                      ready;
	psl_pkg::kind_t            kind;
	logic [psl_pkg::KEY_W-1:0] source_address;

	modport source (output valid, output kind, output source_address, input ready);
	modport sink (input valid, input kind, input source_address, output ready);
endinterface

// File: rtl/core/psl_res_if.sv
// Result channel interface.
`timescale 1ns / 1ps

interface psl_res_if;
	logic                        valid;
	logic                        ready;
	logic                        allowed;
	psl_pkg::status_t            status;
	logic [psl_pkg::COUNT_W-1:0] count_after;

	modport source (output valid, output allowed, output status, output count_after,
		input ready);
	modport sink (input valid, input allowed, input status, input count_after,
		output ready);
endinterface

// File: rtl/core/psl_cell.sv
// One table entry: key, counter and valid bit, with its stage of the request chain.
`timescale 1ns / 1ps

module psl_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [psl_pkg::COUNT_W-1:0] max_per_source,
	input  psl_pkg::token_t             tok_i,
	output psl_pkg::token_t             tok_s1
);

	logic                        valid_q;
	logic [psl_pkg::KEY_W-1:0]   key_q;
	logic [psl_pkg::COUNT_W-1:0] count_q;

	psl_pkg::token_t             tok_nxt;
	logic                        hit;
	logic                        wr_key;
	logic                        wr_count;
	logic [psl_pkg::COUNT_W-1:0] count_nxt;

	assign hit = valid_q && (key_q == tok_i.addr);

	always_comb begin
		tok_nxt   = tok_i;
		wr_key    = 1'b0;
		wr_count  = 1'b0;
		count_nxt = count_q;
		if (tok_i.valid && !tok_i.done) begin
			if (tok_i.kind == psl_pkg::KIND_CONNECT) begin
				if (hit) begin
					tok_nxt.done = 1'b1;
					if (count_q >= max_per_source) begin
						tok_nxt.allowed = 1'b0;
						tok_nxt.status  = psl_pkg::ST_DENY_LIMIT;
						tok_nxt.count   = count_q;
					end else begin
						count_nxt       = count_q + 16'd1;
						wr_count        = 1'b1;
						tok_nxt.allowed = 1'b1;
						tok_nxt.status  = psl_pkg::ST_GRANT_HIT;
						tok_nxt.count   = count_nxt;
					end
				end else if (!valid_q) begin
					// first free cell: append
					wr_key          = 1'b1;
					wr_count        = 1'b1;
					count_nxt       = 16'd1;
					tok_nxt.done    = 1'b1;
					tok_nxt.allowed = 1'b1;
					tok_nxt.status  = psl_pkg::ST_GRANT_NEW;
					tok_nxt.count   = 16'd1;
				end
			end else begin
				if (hit) begin
					tok_nxt.done    = 1'b1;
					tok_nxt.allowed = 1'b0;
					if (count_q != '0) begin
						count_nxt      = count_q - 16'd1;
						wr_count       = 1'b1;
						tok_nxt.status = psl_pkg::ST_RELEASED;
						tok_nxt.count  = count_nxt;
					end else begin
						tok_nxt.status = psl_pkg::ST_UNMATCHED;
						tok_nxt.count  = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_s1  <= '0;
		end else if (en) begin
			tok_s1 <= tok_nxt;
			if (wr_key) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr_key) begin
			key_q <= tok_i.addr;
		end
		if (en && wr_count) begin
			count_q <= count_nxt;
		end
	end

endmodule

// File: rtl/core/per_source_connection_limiter.sv
// Per-source connection limiter: a chain of table cells with an output register.
// Each request walks the chain of TABLE_ENTRIES cells, one cell per cycle while the
// chain advances, and its result is registered at the output; requests enter one
// per cycle unless the chain holds, each following the previous one down the chain
// in order. The whole chain holds while a result waits on res.ready. Occupied cells
// form a prefix, so a connect that misses claims the first free cell; entries are
// never freed. max_per_source resets to 10 and is written via cfg_we / cfg_wdata.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module per_source_connection_limiter #(
	parameter int unsigned TABLE_ENTRIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [psl_pkg::COUNT_W-1:0] cfg_wdata,
	psl_req_if.sink                     req,
	psl_res_if.source                   res
);

	logic [psl_pkg::COUNT_W-1:0] max_q;
	logic                        advance;
	psl_pkg::token_t             chain [TABLE_ENTRIES+1];
	psl_pkg::token_t             tail;

	logic                        res_valid_q;
	logic                        res_allowed_q;
	psl_pkg::status_t            res_status_q;
	logic [psl_pkg::COUNT_W-1:0] res_count_q;

	assign advance   = !res_valid_q || res.ready;
	assign req.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= psl_pkg::MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_comb begin
		chain[0]         = '0;
		chain[0].valid   = req.valid;
		chain[0].kind    = req.kind;
		chain[0].addr    = req.source_address;
		chain[0].done    = 1'b0;
		chain[0].allowed = 1'b0;
		chain[0].status  = psl_pkg::ST_UNMATCHED;
		chain[0].count   = '0;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		psl_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.en             (advance),
			.max_per_source (max_q),
			.tok_i          (chain[i]),
			.tok_s1         (chain[i+1])
		);
	end

	// fell off the chain unmatched
	always_comb begin
		tail = chain[TABLE_ENTRIES];
		if (!tail.done) begin
			tail.allowed = 1'b0;
			tail.count   = '0;
			tail.status  = (tail.kind == psl_pkg::KIND_CONNECT) ?
				psl_pkg::ST_DENY_FULL : psl_pkg::ST_UNMATCHED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_allowed_q <= tail.allowed;
			res_status_q  <= tail.status;
			res_count_q   <= tail.count;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.allowed     = res_allowed_q;
	assign res.status      = res_status_q;
	assign res.count_after = res_count_q;

	`ASSERT_DEFAULT(a_allowed_grant,
		res.valid && res.allowed |-> (res.status == psl_pkg::ST_GRANT_HIT ||
		res.status == psl_pkg::ST_GRANT_NEW),
		"allowed without grant status")
	`ASSERT_DEFAULT(a_new_count_one,
		res.valid && res.status == psl_pkg::ST_GRANT_NEW |-> res.count_after == 16'd1,
		"new entry count not one")
	`ASSERT_DEFAULT(a_nomatch_zero,
		res.valid && (res.status == psl_pkg::ST_DENY_FULL ||
		res.status == psl_pkg::ST_UNMATCHED) |-> res.count_after == '0,
		"unmatched result with nonzero count")
	`ASSERT_DEFAULT(a_stall_cause,
		!req.ready |-> res.valid && !res.ready,
		"input stalled without output backpressure")

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the per-source connection limiter: predicts grants and releases.
`timescale 1ns / 1ps

module tb_top;

	import psl_pkg::*;

	localparam int TAB_DEPTH    = 64;
	localparam int POOL_SIZE    = 64;
	localparam int HOLD_AT      = 700;
	localparam int HOLD_CYCLES  = 150;
	localparam int LIMIT_CYCLES = 200000;
	localparam int PRINT_MAX    = 40;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] addr;
	} conn_req_t;

	typedef struct packed {
		logic               allowed;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} conn_verdict_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	psl_req_if req_ch ();
	psl_res_if res_ch ();

	per_source_connection_limiter #(
		.TABLE_ENTRIES(TAB_DEPTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	// predictor state
	logic [KEY_W-1:0]   tab_key [TAB_DEPTH];
	logic [COUNT_W-1:0] tab_cnt [TAB_DEPTH];
	int                 n_used;
	logic [COUNT_W-1:0] limit_model;
	int                 peak_count;

	conn_req_t     pending_reqs [$];
	conn_verdict_t verdicts_due [$];
	logic [KEY_W-1:0] addr_pool [POOL_SIZE];

	bit  idle_on;
	int  send_gap;
	int  sink_gap;
	int  hold_left;
	bit  hold_fired;
	int  requests_taken;
	int  results_seen;
	int  mismatches;
	int  outcome_tally [6];
	longint cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic conn_verdict_t admit_or_release(conn_req_t r);
		conn_verdict_t v;
		int slot;
		int i;
		v.allowed = 1'b0;
		v.status  = ST_UNMATCHED;
		v.count   = '0;
		slot = -1;
		for (i = n_used - 1; i >= 0; i--)
			if (tab_key[i] == r.addr)
				slot = i;
		if (r.kind == KIND_CONNECT) begin
			if (slot >= 0) begin
				if (tab_cnt[slot] >= limit_model) begin
					v.status = ST_DENY_LIMIT;
					v.count  = tab_cnt[slot];
				end else begin
					tab_cnt[slot] = tab_cnt[slot] + 1'b1;
					v.allowed = 1'b1;
					v.status  = ST_GRANT_HIT;
					v.count   = tab_cnt[slot];
				end
			end else if (n_used < TAB_DEPTH) begin
				tab_key[n_used] = r.addr;
				tab_cnt[n_used] = 16'd1;
				n_used++;
				v.allowed = 1'b1;
				v.status  = ST_GRANT_NEW;
				v.count   = 16'd1;
			end else begin
				v.status = ST_DENY_FULL;
			end
		end else if (slot >= 0 && tab_cnt[slot] != 0) begin
			tab_cnt[slot] = tab_cnt[slot] - 1'b1;
			v.status = ST_RELEASED;
			v.count  = tab_cnt[slot];
		end
		if (int'(v.count) > peak_count)
			peak_count = int'(v.count);
		return v;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < PRINT_MAX)
			$display("tb: mismatch at result %0d: %s got %0d want %0d",
				results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic push_req(input kind_t k, input logic [KEY_W-1:0] a);
		conn_req_t r;
		r.kind = k;
		r.addr = a;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || verdicts_due.size() != 0);
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_model = value;
		@(negedge clk);
	endtask

	// fresh addresses miss the pool; they only open entries when fresh_connects is set
	task automatic run_mix(input logic [COUNT_W-1:0] limit, input int n, input int span,
		input int fresh_pct, input int connect_pct, input bit fresh_connects, input bit gaps);
		int i;
		kind_t k;
		logic [KEY_W-1:0] a;
		write_limit(limit);
		idle_on = gaps;
		for (i = 0; i < n; i++) begin
			k = ($urandom_range(0, 99) < connect_pct) ? KIND_CONNECT : KIND_CLOSE;
			if ($urandom_range(0, 99) < fresh_pct && (fresh_connects || k == KIND_CLOSE))
				a = $urandom;
			else
				a = addr_pool[$urandom_range(0, span - 1)];
			push_req(k, a);
		end
	endtask

	initial begin : stimulus
		int i;
		req_ch.valid          = 1'b0;
		req_ch.kind           = KIND_CONNECT;
		req_ch.source_address = '0;
		res_ch.ready          = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		idle_on               = 1'b1;
		limit_model           = MAX_RESET;
		n_used                = 0;
		peak_count            = 0;
		mismatches            = 0;
		results_seen          = 0;
		for (i = 0; i < 6; i++)
			outcome_tally[i] = 0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;

		@(posedge arst_n);
		@(negedge clk);

		// reset limit: miss close, new, hit, release to zero, close at zero
		push_req(KIND_CLOSE,   addr_pool[0]);
		push_req(KIND_CONNECT, addr_pool[0]);
		push_req(KIND_CONNECT, addr_pool[0]);
		push_req(KIND_CONNECT, addr_pool[1]);
		push_req(KIND_CLOSE,   addr_pool[1]);
		push_req(KIND_CLOSE,   addr_pool[1]);
		push_req(KIND_CLOSE,   addr_pool[0]);

		write_limit(16'd2);
		push_req(KIND_CONNECT, addr_pool[2]);
		push_req(KIND_CONNECT, addr_pool[2]);
		push_req(KIND_CONNECT, addr_pool[2]);
		push_req(KIND_CLOSE,   addr_pool[2]);
		push_req(KIND_CONNECT, addr_pool[2]);

		// limit zero: hits denied, a miss still gets an entry
		write_limit(16'd0);
		push_req(KIND_CONNECT, addr_pool[2]);
		push_req(KIND_CONNECT, addr_pool[3]);
		push_req(KIND_CONNECT, addr_pool[3]);
		push_req(KIND_CLOSE,   addr_pool[3]);
		push_req(KIND_CLOSE,   addr_pool[0]);
		push_req(KIND_CLOSE,   32'h5555_aaaa);

		run_mix(16'd1,     250, 16, 10, 55, 1'b0, 1'b1);
		run_mix(16'hffff,  250, 32, 10, 75, 1'b0, 1'b0);
		run_mix(16'd3,     250, 48, 10, 55, 1'b0, 1'b1);
		run_mix(16'd0,     200, 48, 10, 45, 1'b0, 1'b1);
		run_mix(MAX_RESET, 300, 64, 10, 60, 1'b1, 1'b1);
		run_mix(16'hffff,  300, 64, 10, 70, 1'b1, 1'b1);
		run_mix(16'd2,     300, 64, 10, 55, 1'b1, 1'b0);

		wait_drained();
		repeat (TAB_DEPTH + 8) @(negedge clk);
		if (verdicts_due.size() != 0)
			report_mismatch("results still due", 0, verdicts_due.size());
		$display("tb: %0d requests, %0d results checked, table holds %0d of %0d, peak count %0d",
			requests_taken, results_seen, n_used, TAB_DEPTH, peak_count);
		$display("tb: hit %0d new %0d limit %0d full %0d released %0d unmatched %0d",
			outcome_tally[ST_GRANT_HIT], outcome_tally[ST_GRANT_NEW],
			outcome_tally[ST_DENY_LIMIT], outcome_tally[ST_DENY_FULL],
			outcome_tally[ST_RELEASED], outcome_tally[ST_UNMATCHED]);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		conn_req_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			send_gap     <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (send_gap > 0) begin
				send_gap     <= send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (idle_on && pending_reqs.size() != 0 && $urandom_range(0, 9) == 0) begin
				send_gap     <= $urandom_range(0, 2);
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				nxt = pending_reqs.pop_front();
				req_ch.valid          <= 1'b1;
				req_ch.kind           <= nxt.kind;
				req_ch.source_address <= nxt.addr;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// one long stall of the result side, long enough to back up the request side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			hold_fired <= 1'b0;
		end else if (!hold_fired && requests_taken >= HOLD_AT) begin
			hold_left  <= HOLD_CYCLES;
			hold_fired <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap     <= 0;
		end else if (hold_left != 0) begin
			res_ch.ready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap     <= sink_gap - 1;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			sink_gap     <= $urandom_range(0, 2);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		conn_req_t     got_req;
		conn_verdict_t want;
		if (!arst_n) begin
			requests_taken <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				got_req.kind = req_ch.kind;
				got_req.addr = req_ch.source_address;
				verdicts_due.push_back(admit_or_release(got_req));
				requests_taken <= requests_taken + 1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("result with nothing due, status", res_ch.status, 0);
				end else begin
					want = verdicts_due.pop_front();
					outcome_tally[want.status]++;
					if (res_ch.allowed !== want.allowed)
						report_mismatch("allowed", res_ch.allowed, want.allowed);
					if (res_ch.status !== want.status)
						report_mismatch("status", res_ch.status, want.status);
					if (res_ch.count_after !== want.count)
						report_mismatch("count_after", res_ch.count_after, want.count);
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
